/* sv/rmmq_pkg.sv */
// shared constants, codes and state type for the range min/max query block
package rmmq_pkg;

    localparam int POS_W    = 11;   // position and count fields
    localparam int IN_VAL_W = 32;   // value field of a load
    localparam int OUT_W    = 32;   // result fields

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_DOWN,
        ST_LOAD_UP,
        ST_QUERY_WALK,
        ST_QUERY_DRAIN
    } rmmq_state_t;

endpackage

/* sv/rmmq_if.sv */
// valid/ready channel interfaces: request, response and count configuration
interface rmmq_req_if import rmmq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [POS_W-1:0]  position;
    logic [IN_VAL_W-1:0] value;
    logic [POS_W-1:0]  range_start;
    logic [POS_W-1:0]  range_end;

    modport source (
        output valid, cmd, position, value, range_start, range_end,
        input  ready
    );
    modport sink (
        input  valid, cmd, position, value, range_start, range_end,
        output ready
    );
endinterface

interface rmmq_rsp_if import rmmq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] range_min;
    logic [OUT_W-1:0] range_max;

    modport source (
        output valid, range_min, range_max,
        input  ready
    );
    modport sink (
        input  valid, range_min, range_max,
        output ready
    );
endinterface

interface rmmq_cfg_if import rmmq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] count_in_use;

    modport source (
        output valid, count_in_use,
        input  ready
    );
    modport sink (
        input  valid, count_in_use,
        output ready
    );
endinterface

/* sv/rmmq_ram.sv */
// generic simple dual-port ram with registered read
module rmmq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/range_min_max_query.sv */
// top level: segment tree range minimum / maximum query engine
//
// Keeps an array of unsigned values (positions 1..count_in_use) as a segment
// tree whose nodes each hold the minimum and maximum of the positions below
// them, packed as one word of a single node ram (2 * 2^ceil(log2(DEPTH))
// words, root at word 1, children of node n at 2n and 2n+1). A load (cmd 0)
// writes one leaf and rebuilds its ancestors; it produces no response. A query
// (cmd 1) returns the minimum and maximum over range_start..range_end,
// clipped to 1..count_in_use; an empty or reversed range returns all-ones and
// zero. A load walks down from the root to its leaf, writes the leaf, rebuilds
// each ancestor on the way up and returns to idle; a load outside the count is
// dropped without leaving idle. A query walks down the nodes that overlap its
// range, reading each node wholly inside it, then drains into the result; a
// range that misses the tree goes straight to the drain. The node ram has one
// read port, so the walk reads one node per cycle. One item is worked at a
// time; a finished response sits in an output register and the next request
// transfer is taken while it waits, but the next query cannot finish until
// that response has gone. Writing count_in_use (0 acts as 1, above DEPTH
// acts as DEPTH) changes the tree shape, so positions must be reloaded before
// they are queried; reading positions never loaded gives unspecified values.
// Configure only while the block is idle.
module range_min_max_query
    import rmmq_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 32
)(
    input  logic       clk,
    input  logic       rst_n,
    rmmq_cfg_if.sink   cfg,
    rmmq_req_if.sink   req,
    rmmq_rsp_if.source rsp
);

    // position/count width: wide enough for DEPTH and for the input fields
    localparam int CNT_W     = ($clog2(DEPTH + 1) > POS_W) ? $clog2(DEPTH + 1) : POS_W;
    localparam int NODE_W    = $clog2(DEPTH) + 1;
    localparam int NODES     = 2 ** NODE_W;
    localparam int NV_W      = 2 * VALUE_BITS;
    // pending right children never exceed the tree height
    localparam int STK_DEPTH = NODE_W;
    localparam int STK_IDX_W = $clog2(STK_DEPTH);
    localparam int SP_W      = $clog2(STK_DEPTH + 1);

    localparam logic [CNT_W-1:0]      CNT_MAX  = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0]      CNT_ONE  = CNT_W'(1);
    localparam logic [NODE_W-1:0]     ROOT     = NODE_W'(1);
    localparam logic [VALUE_BITS-1:0] VAL_ONES = '1;
    localparam logic [VALUE_BITS-1:0] VAL_ZERO = '0;
    localparam logic [SP_W-1:0]       SP_ONE   = SP_W'(1);

    // one tree node under walk: covered positions and ram word
    typedef struct packed {
        logic [CNT_W-1:0]  lo;
        logic [CNT_W-1:0]  hi;
        logic [NODE_W-1:0] node;
    } walk_t;

    rmmq_state_t state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [SP_W-1:0]       sp_reg, sp_next;
    logic                  pend_reg, pend_next;
    logic                  out_valid_reg, out_valid_next;

    walk_t                 cur_reg, cur_next;
    logic [CNT_W-1:0]      qs_reg, qs_next;     // query start, or load position
    logic [CNT_W-1:0]      qe_reg, qe_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [VALUE_BITS-1:0] acc_min_reg, acc_min_next;
    logic [VALUE_BITS-1:0] acc_max_reg, acc_max_next;
    logic [VALUE_BITS-1:0] out_min_reg, out_min_next;
    logic [VALUE_BITS-1:0] out_max_reg, out_max_next;
    walk_t                 stk_reg [STK_DEPTH];

    // node ram port signals
    logic                  ram_we;
    logic [NODE_W-1:0]     ram_waddr;
    logic [NV_W-1:0]       ram_wdata;
    logic [NODE_W-1:0]     ram_raddr;
    logic [NV_W-1:0]       ram_rdata;

    logic                  stk_push;
    walk_t                 stk_top;
    logic [SP_W-1:0]       sp_m1;

    logic [CNT_W:0]        lohi_sum;
    logic [CNT_W-1:0]      mid;
    walk_t                 left_child;
    walk_t                 right_child;
    logic [NODE_W-1:0]     sibling;
    logic [NODE_W-1:0]     parent;
    logic [VALUE_BITS-1:0] rd_min;
    logic [VALUE_BITS-1:0] rd_max;
    logic [VALUE_BITS-1:0] mrg_min;
    logic [VALUE_BITS-1:0] mrg_max;

    logic [VALUE_BITS-1:0] val_in;
    logic [CNT_W-1:0]      pos_in;
    logic [CNT_W-1:0]      rs_in;
    logic [CNT_W-1:0]      re_in;
    logic [CNT_W-1:0]      cfg_in;
    logic                  req_xfer;
    logic                  covered;

    rmmq_ram #(
        .WIDTH (NV_W),
        .DEPTH (NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // value field to storage width and back to the result width
    generate
        if (VALUE_BITS >= IN_VAL_W)
        begin : g_val_wide
            assign val_in = VALUE_BITS'(req.value);
        end
        else
        begin : g_val_narrow
            assign val_in = req.value[VALUE_BITS-1:0];
        end

        if (VALUE_BITS >= OUT_W)
        begin : g_out_trunc
            assign rsp.range_min = out_min_reg[OUT_W-1:0];
            assign rsp.range_max = out_max_reg[OUT_W-1:0];
        end
        else
        begin : g_out_ext
            assign rsp.range_min = OUT_W'(out_min_reg);
            assign rsp.range_max = OUT_W'(out_max_reg);
        end
    endgenerate

    assign pos_in   = CNT_W'(req.position);
    assign rs_in    = CNT_W'(req.range_start);
    assign re_in    = CNT_W'(req.range_end);
    assign cfg_in   = CNT_W'(cfg.count_in_use);

    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;

    // split of the current node
    assign lohi_sum = {1'b0, cur_reg.lo} + {1'b0, cur_reg.hi};
    assign mid      = lohi_sum[CNT_W:1];
    assign left_child  = '{lo: cur_reg.lo, hi: mid,
                           node: {cur_reg.node[NODE_W-2:0], 1'b0}};
    assign right_child = '{lo: mid + CNT_ONE, hi: cur_reg.hi,
                           node: {cur_reg.node[NODE_W-2:0], 1'b1}};
    assign sibling  = {cur_reg.node[NODE_W-1:1], ~cur_reg.node[0]};
    assign parent   = {1'b0, cur_reg.node[NODE_W-1:1]};
    assign covered  = (qs_reg <= cur_reg.lo) && (cur_reg.hi <= qe_reg);

    // node word just read merged into the running min/max
    assign rd_min  = ram_rdata[NV_W-1:VALUE_BITS];
    assign rd_max  = ram_rdata[VALUE_BITS-1:0];
    assign mrg_min = (rd_min < acc_min_reg) ? rd_min : acc_min_reg;
    assign mrg_max = (rd_max > acc_max_reg) ? rd_max : acc_max_reg;

    assign sp_m1   = sp_reg - SP_ONE;
    assign stk_top = stk_reg[sp_m1[STK_IDX_W-1:0]];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sp_next        = sp_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        cur_next       = cur_reg;
        qs_next        = qs_reg;
        qe_next        = qe_reg;
        val_next       = val_reg;
        acc_min_next   = acc_min_reg;
        acc_max_next   = acc_max_reg;
        out_min_next   = out_min_reg;
        out_max_next   = out_max_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg.node;
        ram_wdata      = {val_reg, val_reg};
        ram_raddr      = cur_reg.node;
        stk_push       = 1'b0;

        // count register, clamped to 1..DEPTH
        if (cfg.valid && cfg.ready)
        begin
            if (cfg_in == '0)
            begin
                count_next = CNT_ONE;
            end
            else if (cfg_in > CNT_MAX)
            begin
                count_next = CNT_MAX;
            end
            else
            begin
                count_next = cfg_in;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    cur_next = '{lo: CNT_ONE, hi: count_reg, node: ROOT};
                    if (req.cmd == CMD_LOAD)
                    begin
                        qs_next  = pos_in;
                        val_next = val_in;
                        // out-of-range load positions are dropped
                        if ((pos_in != '0) && (pos_in <= count_reg))
                        begin
                            state_next = ST_LOAD_DOWN;
                        end
                    end
                    else
                    begin
                        qs_next      = rs_in;
                        qe_next      = re_in;
                        acc_min_next = VAL_ONES;
                        acc_max_next = VAL_ZERO;
                        pend_next    = 1'b0;
                        sp_next      = '0;
                        // range must overlap the root, else neutral result
                        if ((rs_in <= re_in) && (rs_in <= count_reg) && (re_in != '0))
                        begin
                            state_next = ST_QUERY_WALK;
                        end
                        else
                        begin
                            state_next = ST_QUERY_DRAIN;
                        end
                    end
                end
            end

            ST_LOAD_DOWN:
            begin
                if (cur_reg.lo == cur_reg.hi)
                begin
                    // leaf reached: write it, then fetch its sibling
                    ram_we       = 1'b1;
                    ram_waddr    = cur_reg.node;
                    ram_wdata    = {val_reg, val_reg};
                    acc_min_next = val_reg;
                    acc_max_next = val_reg;
                    ram_raddr    = sibling;
                    if (cur_reg.node == ROOT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_LOAD_UP;
                    end
                end
                else if (qs_reg <= mid)
                begin
                    cur_next = left_child;
                end
                else
                begin
                    cur_next = right_child;
                end
            end

            ST_LOAD_UP:
            begin
                // sibling word is on the read port: rebuild the parent
                ram_we        = 1'b1;
                ram_waddr     = parent;
                ram_wdata     = {mrg_min, mrg_max};
                acc_min_next  = mrg_min;
                acc_max_next  = mrg_max;
                cur_next.node = parent;
                ram_raddr     = {parent[NODE_W-1:1], ~parent[0]};
                if (parent == ROOT)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_QUERY_WALK:
            begin
                if (pend_reg)
                begin
                    acc_min_next = mrg_min;
                    acc_max_next = mrg_max;
                end
                if (covered)
                begin
                    // whole node inside the range: read it, take next pending node
                    ram_raddr = cur_reg.node;
                    pend_next = 1'b1;
                    if (sp_reg == '0)
                    begin
                        state_next = ST_QUERY_DRAIN;
                    end
                    else
                    begin
                        cur_next = stk_top;
                        sp_next  = sp_m1;
                    end
                end
                else
                begin
                    // partial overlap: descend only into overlapping children
                    pend_next = 1'b0;
                    if (qs_reg <= mid)
                    begin
                        cur_next = left_child;
                        if (qe_reg > mid)
                        begin
                            stk_push = 1'b1;
                            sp_next  = sp_reg + SP_ONE;
                        end
                    end
                    else
                    begin
                        cur_next = right_child;
                    end
                end
            end

            ST_QUERY_DRAIN:
            begin
                pend_next = 1'b0;
                if (pend_reg)
                begin
                    acc_min_next = mrg_min;
                    acc_max_next = mrg_max;
                end
                else if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_min_next   = acc_min_reg;
                    out_max_next   = acc_max_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= CNT_MAX;
            sp_reg        <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sp_reg        <= sp_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        qs_reg      <= qs_next;
        qe_reg      <= qe_next;
        val_reg     <= val_next;
        acc_min_reg <= acc_min_next;
        acc_max_reg <= acc_max_next;
        out_min_reg <= out_min_next;
        out_max_reg <= out_max_next;
        if (stk_push)
        begin
            stk_reg[sp_reg[STK_IDX_W-1:0]] <= right_child;
        end
    end

endmodule

/* tb/sv/rmmq_checker.sv */
// checker for the range min/max query block: segment tree predictor and response compare
`timescale 1ns / 100ps

module rmmq_checker
    import rmmq_pkg::*;
#(
    parameter int DEPTH = 1024
)(
    input  logic clk,
    input  logic rst_n,
    rmmq_cfg_if  cfg,
    rmmq_req_if  req,
    rmmq_rsp_if  rsp,
    output int   fail_count,
    output int   pending
);

    localparam int SLOTS       = 4 * DEPTH + 4;
    localparam int STACK_DEPTH = 64;

    typedef struct packed {
        logic [OUT_W-1:0] lowest;
        logic [OUT_W-1:0] highest;
    } min_max_t;

    logic [OUT_W-1:0] node_min [SLOTS];
    logic [OUT_W-1:0] node_max [SLOTS];
    int               tree_count;
    min_max_t         answers_q [$];
    min_max_t         got;
    min_max_t         want;

    function automatic int clamp_count(input int v);
        if (v < 1)
            return 1;
        if (v > DEPTH)
            return DEPTH;
        return v;
    endfunction

    // write one leaf, then rebuild its ancestors bottom-up
    function automatic void tree_load(input int pos, input logic [OUT_W-1:0] v);
        int path [STACK_DEPTH];
        int levels;
        int lo;
        int hi;
        int mid;
        int node;
        int n;
        int i;
        lo     = 1;
        hi     = tree_count;
        node   = 1;
        levels = 0;
        while (lo != hi)
        begin
            path[levels] = node;
            levels++;
            mid = (lo + hi) / 2;
            if (pos <= mid)
            begin
                hi   = mid;
                node = 2 * node;
            end
            else
            begin
                lo   = mid + 1;
                node = 2 * node + 1;
            end
        end
        node_min[node] = v;
        node_max[node] = v;
        for (i = levels - 1; i >= 0; i--)
        begin
            n = path[i];
            node_min[n] = (node_min[2*n] < node_min[2*n+1]) ? node_min[2*n] : node_min[2*n+1];
            node_max[n] = (node_max[2*n] > node_max[2*n+1]) ? node_max[2*n] : node_max[2*n+1];
        end
    endfunction

    // the usual top-down walk, with an explicit stack of pending nodes
    function automatic min_max_t tree_query(input int qs, input int qe);
        int       stk_lo   [STACK_DEPTH];
        int       stk_hi   [STACK_DEPTH];
        int       stk_node [STACK_DEPTH];
        int       sp;
        int       lo;
        int       hi;
        int       mid;
        int       node;
        min_max_t acc;
        acc.lowest  = '1;
        acc.highest = '0;
        if (qs > qe)
            return acc;
        sp          = 1;
        stk_lo[0]   = 1;
        stk_hi[0]   = tree_count;
        stk_node[0] = 1;
        while (sp > 0)
        begin
            sp--;
            lo   = stk_lo[sp];
            hi   = stk_hi[sp];
            node = stk_node[sp];
            if (lo > qe || hi < qs)
                continue;
            if (qs <= lo && hi <= qe)
            begin
                if (node_min[node] < acc.lowest)
                    acc.lowest = node_min[node];
                if (node_max[node] > acc.highest)
                    acc.highest = node_max[node];
                continue;
            end
            mid          = (lo + hi) / 2;
            stk_lo[sp]   = lo;
            stk_hi[sp]   = mid;
            stk_node[sp] = 2 * node;
            sp++;
            stk_lo[sp]   = mid + 1;
            stk_hi[sp]   = hi;
            stk_node[sp] = 2 * node + 1;
            sp++;
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t checker: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_count = DEPTH;
            answers_q.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                tree_count = clamp_count(int'(cfg.count_in_use));
            if (rsp.valid && rsp.ready)
            begin
                got.lowest  = rsp.range_min;
                got.highest = rsp.range_max;
                if (answers_q.size() == 0)
                    report_mismatch($sformatf("response min %h max %h with no query waiting",
                                              got.lowest, got.highest));
                else
                begin
                    want = answers_q.pop_front();
                    if (got.lowest !== want.lowest)
                        report_mismatch($sformatf("range_min got %h expected %h",
                                                  got.lowest, want.lowest));
                    if (got.highest !== want.highest)
                        report_mismatch($sformatf("range_max got %h expected %h",
                                                  got.highest, want.highest));
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.cmd == CMD_QUERY)
                    answers_q.push_back(tree_query(int'(req.range_start), int'(req.range_end)));
                else if (req.position >= 1 && int'(req.position) <= tree_count)
                    tree_load(int'(req.position), req.value);
            end
            pending <= answers_q.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// testbench top for range_min_max_query: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb_top;
    import rmmq_pkg::*;

    localparam int DEPTH         = 1024;
    localparam int MAX_POS       = (1 << POS_W) - 1;   // largest value an 11-bit field holds
    localparam int WINDOW        = 48;                 // load window for large counts
    localparam int SETTLE_CYCLES = 40;                 // settling gap; the tree height is at most 10
    localparam int STALL_LIMIT   = 5000;               // cycles with no transfer at all
    localparam int IDLE_PCT      = 19;

    typedef struct {
        logic                cmd;
        logic [POS_W-1:0]    position;
        logic [IN_VAL_W-1:0] value;
        logic [POS_W-1:0]    range_start;
        logic [POS_W-1:0]    range_end;
    } req_item_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;

    // stimulus bookkeeping: which positions hold a value under the current count
    bit   loaded [0:MAX_POS];
    int   loaded_list [$];
    int   cur_count;
    int   win_base;
    bit   steady;
    int   quiet_cycles;

    // run statistics for the summary
    int   loads_kept;
    int   loads_ignored;
    int   queries_sent;
    int   settings_made;

    rmmq_cfg_if cfg_ch ();
    rmmq_req_if req_ch ();
    rmmq_rsp_if rsp_ch ();

    range_min_max_query #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (32)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rmmq_checker #(
        .DEPTH (DEPTH)
    ) tree_watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 20 ns clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // response side: stalls about one cycle in five, never during a steady phase
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog: a run that stops moving is a failure
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
                     STALL_LIMIT, pending);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int clamp_count(input int v);
        if (v < 1)
            return 1;
        if (v > DEPTH)
            return DEPTH;
        return v;
    endfunction

    // mostly random words, with the extremes and small values that make ties
    function automatic logic [IN_VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 35)
            return IN_VAL_W'($urandom_range(0, 15));
        return $urandom;
    endfunction

    // present one item and hold it until the transfer; an optional gap goes first
    task automatic put_item(input req_item_t item);
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 40);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= item.cmd;
        req_ch.position    <= item.position;
        req_ch.value       <= item.value;
        req_ch.range_start <= item.range_start;
        req_ch.range_end   <= item.range_end;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic send_load(input int pos, input logic [IN_VAL_W-1:0] val);
        req_item_t item;
        item.cmd         = CMD_LOAD;
        item.position    = POS_W'(pos);
        item.value       = val;
        item.range_start = POS_W'($urandom);
        item.range_end   = POS_W'($urandom);
        // a position outside 1..count is dropped by the block
        if (pos >= 1 && pos <= cur_count)
        begin
            loads_kept++;
            if (!loaded[pos])
            begin
                loaded[pos] = 1'b1;
                loaded_list.push_back(pos);
            end
        end
        else
            loads_ignored++;
        put_item(item);
    endtask

    task automatic send_query(input int qs, input int qe);
        req_item_t item;
        item.cmd         = CMD_QUERY;
        item.position    = POS_W'($urandom);
        item.value       = $urandom;
        item.range_start = POS_W'(qs);
        item.range_end   = POS_W'(qe);
        queries_sent++;
        put_item(item);
    endtask

    // hold the sender off until every query has been answered
    task automatic wait_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // block is idle here; new tree shape, so nothing counts as loaded any more
    task automatic apply_count(input int v);
        int i;
        cfg_ch.valid        <= 1'b1;
        cfg_ch.count_in_use <= POS_W'(v);
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_count = clamp_count(v);
        for (i = 0; i <= MAX_POS; i++)
            loaded[i] = 1'b0;
        loaded_list.delete();
        settings_made++;
    endtask

    // load position: anywhere for small counts, mostly inside a window for large ones
    function automatic int pick_position();
        int pos;
        if (cur_count <= 64 || $urandom_range(99) < 15)
            return $urandom_range(1, cur_count);
        pos = win_base + $urandom_range(0, WINDOW - 1);
        return (pos > cur_count) ? cur_count : pos;
    endfunction

    // a query over a run of loaded positions, or one of the empty kinds
    task automatic random_query();
        int r;
        int anchor;
        int lo;
        int hi;
        int reach;
        int steps;
        int qs;
        int qe;
        r = $urandom_range(99);
        if (r < 8)
        begin
            // reversed range
            qs = $urandom_range(1, MAX_POS);
            qe = $urandom_range(0, qs - 1);
        end
        else if (r < 13)
        begin
            // wholly above the count
            qs = $urandom_range(cur_count + 1, MAX_POS);
            qe = $urandom_range(qs, MAX_POS);
        end
        else
        begin
            anchor = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            reach  = ($urandom_range(3) == 0) ? MAX_POS : $urandom_range(0, 8);
            lo     = anchor;
            steps  = 0;
            while (lo > 1 && loaded[lo-1] && steps < reach)
            begin
                lo--;
                steps++;
            end
            hi    = anchor;
            steps = 0;
            while (hi < cur_count && loaded[hi+1] && steps < reach)
            begin
                hi++;
                steps++;
            end
            // at the edges of the tree the range may stick out past them
            qs = (lo == 1 && $urandom_range(3) == 0) ? 0 : lo;
            qe = (hi == cur_count && $urandom_range(3) == 0) ? $urandom_range(hi, MAX_POS) : hi;
        end
        send_query(qs, qe);
    endtask

    // one count setting: loads and queries mixed, with a little ignored-load noise
    task automatic run_phase(input int count_word, input int n_items, input bit no_gaps);
        int done;
        int r;
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        apply_count(count_word);
        steady = no_gaps;
        case ($urandom_range(2))
            0:       win_base = 1;
            1:       win_base = (cur_count > WINDOW) ? cur_count - WINDOW + 1 : 1;
            default: win_base = $urandom_range(1, (cur_count > WINDOW) ? cur_count - WINDOW + 1 : 1);
        endcase
        done = 0;
        while (done < n_items)
        begin
            // halfway through, wait until every query has been answered
            if (done == n_items / 2)
                wait_results();
            r = $urandom_range(99);
            if (r < 6)
            begin
                if ($urandom_range(1) == 0)
                    send_load(0, pick_value());
                else
                    send_load($urandom_range(cur_count + 1, MAX_POS), pick_value());
                continue;
            end
            if (r < 45 || loaded_list.size() == 0)
                send_load(pick_position(), pick_value());
            else
                random_query();
            done++;
        end
        steady = 1'b0;
    endtask

    // small tree with hand-picked values: extremes, ignored loads, clipped and empty ranges
    task automatic directed_checks();
        apply_count(4);
        send_load(1, 32'h0000_0000);
        send_load(2, 32'hFFFF_FFFF);
        send_load(3, 32'h0000_0005);
        send_load(4, 32'h8000_0000);
        send_load(0, 32'h0000_0007);        // position zero, dropped
        send_load(5, 32'h0000_0009);        // just past the count, dropped
        send_load(MAX_POS, 32'h0000_0001);  // top of the field, dropped
        send_query(1, 4);
        send_query(2, 2);
        send_query(3, 4);
        send_query(4, 1);                   // reversed
        send_query(0, MAX_POS);             // sticks out on both sides
        send_query(5, MAX_POS);             // wholly above the count
        send_query(MAX_POS, MAX_POS);
        send_query(0, 0);
        send_query(0, 1);
        send_load(1, 32'hFFFF_FFFF);        // overwrite an existing leaf
        send_query(1, 3);
        send_load(3, 32'h7FFF_FFFF);
        send_query(1, 4);
        send_query(3, 3);
    endtask

    initial
    begin
        steady        = 1'b0;
        loads_kept    = 0;
        loads_ignored = 0;
        queries_sent  = 0;
        settings_made = 0;
        cur_count     = DEPTH;

        req_ch.valid        <= 1'b0;
        req_ch.cmd          <= CMD_LOAD;
        req_ch.position     <= '0;
        req_ch.value        <= '0;
        req_ch.range_start  <= '0;
        req_ch.range_end    <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.count_in_use <= POS_W'(DEPTH);

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();

        // count words include 0 and 2047, which the block clamps to 1 and 1024
        run_phase(0,       30,  1'b0);
        run_phase(MAX_POS, 120, 1'b0);
        run_phase(2,       30,  1'b0);
        run_phase(3,       40,  1'b0);
        run_phase(7,       60,  1'b0);
        run_phase(1,       20,  1'b0);
        run_phase(64,      100, 1'b1);      // long run with no gaps on either side
        run_phase(100,     100, 1'b0);
        run_phase(1000,    100, 1'b0);
        run_phase(513,     80,  1'b0);
        run_phase(DEPTH,   80,  1'b0);

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("summary: %0d loads kept, %0d loads outside the count, %0d queries",
                 loads_kept, loads_ignored, queries_sent);
        $display("summary: %0d count settings, tree sizes from 1 to %0d, %0d mismatches",
                 settings_made, DEPTH, fail_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
sv/rmmq_pkg.sv
sv/rmmq_if.sv
sv/rmmq_ram.sv
sv/range_min_max_query.sv
tb/sv/rmmq_checker.sv
tb/sv/tb_top.sv
